FILE: rtl/cbq_pkg.sv
// ----------------------------------------------------------------------------
// cbq_pkg
// Shared types, constants and arithmetic helpers for the cascaded biquad bank.
// ----------------------------------------------------------------------------
package cbq_pkg;

  // Coefficient and delay-state words within one biquad's block of words
  localparam int unsigned COEFS_PER_BIQUAD  = 7;
  localparam int unsigned STATES_PER_BIQUAD = 4;

  // Width of a biquad index (covers branch start plus series length)
  localparam int unsigned BQ_IDX_W = 7;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_BIQUAD_COUNT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SERIES_LENGTH = CFG_IDX_W'(1);

  // Step codes of the per-biquad sequence
  localparam logic [3:0] STEP_RD_X1   = 4'd3;  // read of x(n-1) slot
  localparam logic [3:0] STEP_RD_LAST = 4'd6;  // last RAM read (gain)
  localparam logic [3:0] STEP_Y       = 4'd7;  // output rounding, write x(n-1)
  localparam logic [3:0] STEP_GAIN    = 4'd8;  // gain multiply, write y(n-1)
  localparam logic [3:0] STEP_OUT     = 4'd9;  // gain shift, write y(n-2)
  localparam logic [3:0] STEP_LAST    = 4'd10; // write x(n-2)

  localparam logic [2:0] SLOT_B0    = 3'd4;
  localparam logic [2:0] SLOT_SHIFT = 3'd5;
  localparam logic [2:0] SLOT_GAIN  = 3'd6;
  localparam logic [1:0] DLY_Y2 = 2'd0;
  localparam logic [1:0] DLY_Y1 = 2'd1;
  localparam logic [1:0] DLY_X2 = 2'd2;
  localparam logic [1:0] DLY_X1 = 2'd3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BRANCH,
    ST_BQ,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic                clear;
    logic                coef_wr;
    logic                load;
    logic                bypass;
    logic                branch_start;
    logic                branch_end;
    logic                step_en;
    logic [3:0]          step;
    logic [BQ_IDX_W-1:0] bq;
    logic                out_load;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_busy;
  } status_t;

  function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
    logic signed [31:0] r;
    if (v > 65'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -65'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Round shift by k: shift by k-1, add one, shift by one; amt = k-1
  function automatic logic signed [31:0] round_sat(input logic signed [63:0] v,
                                                   input logic [5:0] amt);
    logic signed [63:0] t;
    logic signed [64:0] u;
    t = v >>> amt;
    u = {t[63], t} + 65'sd1;
    return sat32(u >>> 1);
  endfunction

endpackage

FILE: rtl/cascaded_biquad_df1_filter.sv
// ----------------------------------------------------------------------------
// cascaded_biquad_df1_filter
// Bank of direct-form-I biquads arranged as parallel branches of series
// sections, with coefficient writes carried in-band on the input channel.
// ----------------------------------------------------------------------------
// A sample word (mode 0) runs through every branch in turn; each biquad in use
// runs its steps on the single shared 32x32 multiplier and the two RAMs
// (seven reads, five taps plus the gain product, four delay-line writes on
// the one write port), and each branch starts with a set-up state. A bypassed
// sample (biquad count zero) skips the branch loop, and a coefficient word
// (mode 1) is written as it is taken. Coefficient words go into the table
// at index biquad*7 + slot (a2, a1, b2, b1, b0, shift, gain); an index past
// the table is dropped. After reset both RAMs are zeroed by a clearing pass
// over MAX_BIQUADS*7 addresses (56 by default), during which no word is taken;
// configuration writes are taken at all times but must only be issued while
// the block is idle. A finished sample waits in the output register while the
// next word is taken.
module cascaded_biquad_df1_filter #(
  parameter int unsigned MAX_BIQUADS = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           mode_i,
  input  logic signed [31:0]             sample_in_i,
  input  logic [5:0]                     coef_index_i,
  input  logic signed [31:0]             coef_value_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [31:0]             sample_out_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [cbq_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [cbq_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  cbq_pkg::cmd_t    cmd;
  cbq_pkg::status_t status;

  // Sequencer: owns the configuration registers and the loops
  cbq_ctrl #(.MAX_BIQUADS(MAX_BIQUADS)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // Arithmetic, storage and the output register
  cbq_dp #(.MAX_BIQUADS(MAX_BIQUADS)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sample_in_i  (sample_in_i),
    .coef_index_i (coef_index_i),
    .coef_value_i (coef_value_i),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .sample_out_o (sample_out_o),
    .cmd_i        (cmd),
    .status_o     (status)
  );

endmodule

FILE: rtl/cbq_ram.sv
// ----------------------------------------------------------------------------
// cbq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module cbq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 56
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/cbq_ctrl.sv
// ----------------------------------------------------------------------------
// cbq_ctrl
// Sequencer: clearing pass, branch and biquad loops, output hand-off.
// ----------------------------------------------------------------------------
module cbq_ctrl #(
  parameter int unsigned MAX_BIQUADS = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            mode_i,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [cbq_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [cbq_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output cbq_pkg::cmd_t                   cmd_o,
  input  cbq_pkg::status_t                status_i
);

  localparam int unsigned BW = cbq_pkg::BQ_IDX_W;
  localparam logic [BW-1:0] MaxBq = BW'(MAX_BIQUADS);

  cbq_pkg::state_e state_q, state_d;
  logic [3:0]    bcount_q, serlen_q;
  logic [BW-1:0] j_q, j_d, i_q, i_d;
  logic [3:0]    s_q, s_d;
  logic [BW-1:0] cnt_eff, ser_eff, bq, j_next;
  logic          skip, bq_done;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bcount_q <= 4'd0;
      serlen_q <= 4'd1;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == cbq_pkg::CFG_BIQUAD_COUNT) begin
        bcount_q <= cfg_data_i[3:0];
      end else if (cfg_index_i == cbq_pkg::CFG_SERIES_LENGTH) begin
        serlen_q <= cfg_data_i[3:0];
      end
    end
  end

  always_comb begin
    cnt_eff = (BW'(bcount_q) > MaxBq) ? MaxBq : BW'(bcount_q);
    if (serlen_q == 4'd0) begin
      ser_eff = BW'(1);
    end else if (BW'(serlen_q) > MaxBq) begin
      ser_eff = MaxBq;
    end else begin
      ser_eff = BW'(serlen_q);
    end
  end

  assign bq      = j_q + i_q;
  assign skip    = (bq >= MaxBq);
  assign bq_done = skip || (s_q == cbq_pkg::STEP_LAST);
  assign j_next  = j_q + ser_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cbq_pkg::ST_CLEAR;
      j_q     <= '0;
      i_q     <= '0;
      s_q     <= '0;
    end else begin
      state_q <= state_d;
      j_q     <= j_d;
      i_q     <= i_d;
      s_q     <= s_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    j_d        = j_q;
    i_d        = i_q;
    s_d        = s_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.bq   = bq;
    cmd_o.step = s_q;
    case (state_q)
      cbq_pkg::ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (status_i.clear_last) begin
          state_d = cbq_pkg::ST_IDLE;
        end
      end
      cbq_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (mode_i) begin
            cmd_o.coef_wr = 1'b1;
          end else begin
            cmd_o.load   = 1'b1;
            cmd_o.bypass = (cnt_eff == '0);
            j_d          = '0;
            state_d      = (cnt_eff == '0) ? cbq_pkg::ST_FINISH : cbq_pkg::ST_BRANCH;
          end
        end
      end
      cbq_pkg::ST_BRANCH: begin
        cmd_o.branch_start = 1'b1;
        i_d     = '0;
        s_d     = '0;
        state_d = cbq_pkg::ST_BQ;
      end
      cbq_pkg::ST_BQ: begin
        cmd_o.step_en = !skip;
        if (!bq_done) begin
          s_d = s_q + 4'd1;
        end else begin
          s_d = '0;
          if (i_q == ser_eff - BW'(1)) begin
            cmd_o.branch_end = 1'b1;
            j_d     = j_next;
            state_d = (j_next >= cnt_eff) ? cbq_pkg::ST_FINISH : cbq_pkg::ST_BRANCH;
          end else begin
            i_d = i_q + BW'(1);
          end
        end
      end
      cbq_pkg::ST_FINISH: begin
        if (!status_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = cbq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = cbq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/cbq_dp.sv
// ----------------------------------------------------------------------------
// cbq_dp
// Datapath: coefficient and delay RAMs, shared multiplier, accumulator,
// rounding, branch sum and output register.
// ----------------------------------------------------------------------------
module cbq_dp #(
  parameter int unsigned MAX_BIQUADS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic signed [31:0]  sample_in_i,
  input  logic [5:0]          coef_index_i,
  input  logic signed [31:0]  coef_value_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic signed [31:0]  sample_out_o,
  input  cbq_pkg::cmd_t       cmd_i,
  output cbq_pkg::status_t    status_o
);

  localparam int unsigned CoefWords  = MAX_BIQUADS * cbq_pkg::COEFS_PER_BIQUAD;
  localparam int unsigned StateWords = MAX_BIQUADS * cbq_pkg::STATES_PER_BIQUAD;
  localparam int unsigned CaW  = $clog2(CoefWords);
  localparam int unsigned DaW  = $clog2(StateWords);
  localparam int unsigned SumW = 32 + $clog2(MAX_BIQUADS) + 1;
  localparam int unsigned BW   = cbq_pkg::BQ_IDX_W;

  logic [CaW-1:0] clr_q;
  logic           c_we, d_we;
  logic [CaW-1:0] c_waddr, c_raddr;
  logic [DaW-1:0] d_waddr, d_raddr;
  logic [31:0]    c_wdata, d_wdata, c_rd, d_rd;
  logic [BW+3:0]  c_base, d_base;
  logic [1:0]     d_wslot;

  logic               en_d1_q, en_d2_q;
  logic [3:0]         s_d1_q, s_d2_q;
  logic signed [63:0] prod_q, acc_q;
  logic signed [31:0] x_q, v_q, y_q, y1old_q, x1old_q, shift_q, gain_q;
  logic signed [31:0] mul_a, mul_b;
  logic signed [33:0] amt_raw;
  logic [5:0]         amt;
  logic signed [SumW-1:0] sum_q;
  logic               out_valid_q;
  logic signed [31:0] out_q;

  // Clearing pass counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear) begin
      clr_q <= clr_q + CaW'(1);
    end
  end
  assign status_o.clear_last = (clr_q == CaW'(CoefWords - 1));

  assign c_base = (BW + 4)'(cmd_i.bq) * (BW + 4)'(cbq_pkg::COEFS_PER_BIQUAD);
  assign d_base = (BW + 4)'(cmd_i.bq) * (BW + 4)'(cbq_pkg::STATES_PER_BIQUAD);
  assign c_raddr = CaW'(c_base + (BW + 4)'(cmd_i.step));
  assign d_raddr = DaW'(d_base + (BW + 4)'(cmd_i.step[1:0]));

  // Coefficient RAM write: clearing pass or a coefficient word
  always_comb begin
    if (cmd_i.clear) begin
      c_we    = 1'b1;
      c_waddr = clr_q;
      c_wdata = '0;
    end else begin
      c_we    = cmd_i.coef_wr && (32'(coef_index_i) < 32'(CoefWords));
      c_waddr = CaW'(coef_index_i);
      c_wdata = coef_value_i;
    end
  end

  // Delay RAM write: clearing pass or state update after a biquad
  always_comb begin
    d_wslot = cbq_pkg::DLY_X1;
    d_wdata = v_q;
    case (cmd_i.step)
      cbq_pkg::STEP_Y:    begin d_wslot = cbq_pkg::DLY_X1; d_wdata = v_q;     end
      cbq_pkg::STEP_GAIN: begin d_wslot = cbq_pkg::DLY_Y1; d_wdata = y_q;     end
      cbq_pkg::STEP_OUT:  begin d_wslot = cbq_pkg::DLY_Y2; d_wdata = y1old_q; end
      cbq_pkg::STEP_LAST: begin d_wslot = cbq_pkg::DLY_X2; d_wdata = x1old_q; end
      default:            begin d_wslot = cbq_pkg::DLY_X1; d_wdata = v_q;     end
    endcase
    if (cmd_i.clear) begin
      d_we    = (32'(clr_q) < 32'(StateWords));
      d_waddr = DaW'(clr_q);
      d_wdata = '0;
    end else begin
      d_we    = cmd_i.step_en && (cmd_i.step >= cbq_pkg::STEP_Y);
      d_waddr = DaW'(d_base + (BW + 4)'(d_wslot));
    end
  end

  cbq_ram #(.WIDTH(32), .DEPTH(CoefWords)) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (c_waddr),
    .wdata_i (c_wdata),
    .raddr_i (c_raddr),
    .rdata_o (c_rd)
  );

  cbq_ram #(.WIDTH(32), .DEPTH(StateWords)) u_dly_ram (
    .clk_i   (clk_i),
    .we_i    (d_we),
    .waddr_i (d_waddr),
    .wdata_i (d_wdata),
    .raddr_i (d_raddr),
    .rdata_o (d_rd)
  );

  // Step tags following the RAM read latency
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_d1_q <= 1'b0;
      en_d2_q <= 1'b0;
    end else begin
      en_d1_q <= cmd_i.step_en && (cmd_i.step <= cbq_pkg::STEP_RD_LAST);
      en_d2_q <= en_d1_q && (s_d1_q <= 4'(cbq_pkg::SLOT_B0));
    end
  end
  always_ff @(posedge clk_i) begin
    s_d1_q <= cmd_i.step;
    s_d2_q <= s_d1_q;
  end

  // Shared multiplier: five taps, then the gain
  always_comb begin
    if (cmd_i.step_en && cmd_i.step == cbq_pkg::STEP_GAIN) begin
      mul_a = gain_q;
      mul_b = y_q;
    end else begin
      mul_a = c_rd;
      mul_b = (s_d1_q == 4'(cbq_pkg::SLOT_B0)) ? v_q : d_rd;
    end
  end

  assign amt_raw = 34'sd13 + {{2{shift_q[31]}}, shift_q};
  assign amt = (amt_raw < 34'sd0) ? 6'd0 : (amt_raw > 34'sd63) ? 6'd63 : amt_raw[5:0];

  always_ff @(posedge clk_i) begin
    if ((en_d1_q && s_d1_q <= 4'(cbq_pkg::SLOT_B0)) ||
        (cmd_i.step_en && cmd_i.step == cbq_pkg::STEP_GAIN)) begin
      prod_q <= mul_a * mul_b;
    end
    if (en_d1_q && s_d1_q == 4'(cbq_pkg::DLY_Y1)) y1old_q <= d_rd;
    if (en_d1_q && s_d1_q == cbq_pkg::STEP_RD_X1) x1old_q <= d_rd;
    if (en_d1_q && s_d1_q == 4'(cbq_pkg::SLOT_SHIFT)) shift_q <= c_rd;
    if (en_d1_q && s_d1_q == 4'(cbq_pkg::SLOT_GAIN)) gain_q <= c_rd;
    if (en_d2_q) begin
      acc_q <= ((s_d2_q == 4'd0) ? 64'sd0 : acc_q) + prod_q;
    end
    if (cmd_i.step_en && cmd_i.step == cbq_pkg::STEP_Y) begin
      y_q <= cbq_pkg::round_sat(acc_q, 6'd29);
    end
    if (cmd_i.load) begin
      x_q   <= sample_in_i;
      sum_q <= cmd_i.bypass ? SumW'(sample_in_i) : '0;
    end
    if (cmd_i.branch_start) begin
      v_q <= x_q;
    end else if (cmd_i.step_en && cmd_i.step == cbq_pkg::STEP_OUT) begin
      v_q <= cbq_pkg::round_sat(prod_q, amt);
    end
    if (cmd_i.branch_end) begin
      sum_q <= sum_q + SumW'(v_q);
    end
    if (cmd_i.out_load) begin
      out_q <= cbq_pkg::sat32(65'(sum_q));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_q;

endmodule

FILE: rtl/cbq_checker.sv
// ----------------------------------------------------------------------------
// cbq_checker
// Port-level checks on the biquad bank, bound to the top level.
// ----------------------------------------------------------------------------
module cbq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        mode_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] sample_out_o
);

  // A held result keeps its word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(sample_out_o))
    else $error("result dropped or changed while stalled");

  // A coefficient word never produces a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && mode_i |=> !$rose(out_valid_o))
    else $error("result after coefficient word");

  // A sample word leaves the block busy in the cycle after it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !mode_i |=> !in_ready_o)
    else $error("sample taken without working on it");

  // A new result appears only while no word is being taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result raised from idle");

endmodule

bind cascaded_biquad_df1_filter cbq_checker u_cbq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .mode_i       (mode_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .sample_out_o (sample_out_o)
);
